FILE: hdl/dsps_pkg.sv
// ----------------------------------------------------------------------------
// dsps_pkg
// Shared types, widths and constants for the dual stepper pulse scheduler.
// ----------------------------------------------------------------------------
package dsps_pkg;

  localparam int DEF_NUM_MOTORS = 2;

  localparam int MIN_W   = 16;
  localparam int MAX_W   = 24;
  localparam int SPEED_W = 17;
  localparam int STEPS_W = 31;
  localparam int TIME_W  = 32;
  localparam int POS_W   = 32;
  localparam int SEL_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [SPEED_W-1:0] SPEED_ONE = 17'h10000;
  localparam logic [MIN_W-1:0]   RST_MIN   = 16'd10;
  localparam logic [MAX_W-1:0]   RST_MAX   = 24'd100000;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_IDX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IDX = 2'd1;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_HALT = 2'd2,
    CMD_HOME = 2'd3
  } cmd_e;

  // per-lane command, already qualified by accept; move and home also by motor select
  typedef struct packed {
    logic               tick;
    logic               move;
    logic               home;
    logic               halt;
    logic               neg;
    logic [STEPS_W-1:0] mag;
    logic [SPEED_W-1:0] speed;
  } lane_cmd_t;

  typedef struct packed {
    logic pulse;
    logic dir;
    logic busy;
  } lane_res_t;

  typedef struct packed {
    logic pulse_a;
    logic dir_a;
    logic pulse_b;
    logic dir_b;
    logic busy_a;
    logic busy_b;
    logic status;
  } res_t;

endpackage

FILE: hdl/dsps_interval.sv
// ----------------------------------------------------------------------------
// dsps_interval
// Step interval unit: max - floor(speed * (max - min) / 2^16), floored at min.
// ----------------------------------------------------------------------------
module dsps_interval (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [dsps_pkg::SPEED_W-1:0] speed,
  input  logic [dsps_pkg::MIN_W-1:0]   min_iv,
  input  logic [dsps_pkg::MAX_W-1:0]   max_iv,
  output logic [dsps_pkg::MAX_W-1:0]   interval
);
  import dsps_pkg::*;

  logic [MAX_W-1:0]         min_ext;
  logic [MAX_W-1:0]         span;
  logic [SPEED_W+MAX_W-1:0] prod;
  logic [MAX_W-1:0]         iv;
  logic [MAX_W-1:0]         interval_r;
  logic [MAX_W-1:0]         interval_nxt;

  assign min_ext = {{(MAX_W-MIN_W){1'b0}}, min_iv};
  assign span    = max_iv - min_ext;
  assign prod    = {{MAX_W{1'b0}}, speed} * {{SPEED_W{1'b0}}, span};
  // speed <= 1.0, so the scaled span never exceeds span itself
  assign iv      = max_iv - prod[MAX_W+15:16];

  always_comb begin
    if (max_iv < min_ext) begin
      interval_nxt = min_ext;
    end else if (iv < min_ext) begin
      interval_nxt = min_ext;
    end else begin
      interval_nxt = iv;
    end
  end

  // reset speed is 1.0, which always gives the min interval
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= {{(MAX_W-MIN_W){1'b0}}, RST_MIN};
    end else begin
      interval_r <= interval_nxt;
    end
  end

  assign interval = interval_r;

endmodule

FILE: hdl/dsps_lane.sv
// ----------------------------------------------------------------------------
// dsps_lane
// One motor channel: step/home state, due-time check and step countdown.
// ----------------------------------------------------------------------------
module dsps_lane (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dsps_pkg::lane_cmd_t          cmd,
  input  logic [dsps_pkg::TIME_W-1:0]  now,
  input  logic [dsps_pkg::POS_W-1:0]   pos,
  input  logic [dsps_pkg::MIN_W-1:0]   min_iv,
  input  logic [dsps_pkg::MAX_W-1:0]   max_iv,
  output dsps_pkg::lane_res_t          res
);
  import dsps_pkg::*;

  logic [STEPS_W-1:0] steps_r,  steps_nxt;
  logic [TIME_W-1:0]  due_r,    due_nxt;
  logic [SPEED_W-1:0] speed_r,  speed_nxt;
  logic               mdir_r,   mdir_nxt;
  logic               pin_r,    pin_nxt;
  logic               homing_r, homing_nxt;
  logic               pulse;
  logic               is_due;
  logic [MAX_W-1:0]   interval;
  logic [TIME_W-1:0]  due_step;

  // interval tracks the speed this lane will hold after the current word
  dsps_interval u_iv (
    .clk      (clk),
    .rst_n    (rst_n),
    .speed    (speed_nxt),
    .min_iv   (min_iv),
    .max_iv   (max_iv),
    .interval (interval)
  );

  assign is_due   = !(now < due_r);
  assign due_step = now + {{(TIME_W-MAX_W){1'b0}}, interval};

  always_comb begin
    steps_nxt  = steps_r;
    due_nxt    = due_r;
    speed_nxt  = speed_r;
    mdir_nxt   = mdir_r;
    pin_nxt    = pin_r;
    homing_nxt = homing_r;
    pulse      = 1'b0;
    if (cmd.tick) begin
      if (homing_r) begin
        if (pos == '0) begin
          homing_nxt = 1'b0;
        end else if (is_due) begin
          pin_nxt = pos[POS_W-1];
          due_nxt = due_step;
          pulse   = 1'b1;
        end
      end else if ((steps_r != '0) && is_due) begin
        pin_nxt   = mdir_r;
        steps_nxt = steps_r - STEPS_W'(1);
        due_nxt   = due_step;
        pulse     = 1'b1;
      end
    end
    if (cmd.move) begin
      steps_nxt = cmd.mag;
      mdir_nxt  = !cmd.neg;
      speed_nxt = cmd.speed;
    end
    if (cmd.home) begin
      homing_nxt = 1'b1;
      speed_nxt  = SPEED_ONE;
    end
    if (cmd.halt) begin
      steps_nxt  = '0;
      homing_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r  <= '0;
      due_r    <= '0;
      speed_r  <= SPEED_ONE;
      mdir_r   <= 1'b1;
      pin_r    <= 1'b0;
      homing_r <= 1'b0;
    end else begin
      steps_r  <= steps_nxt;
      due_r    <= due_nxt;
      speed_r  <= speed_nxt;
      mdir_r   <= mdir_nxt;
      pin_r    <= pin_nxt;
      homing_r <= homing_nxt;
    end
  end

  assign res.pulse = pulse;
  assign res.dir   = pin_nxt;
  assign res.busy  = homing_nxt || (steps_nxt != '0);

endmodule

FILE: hdl/dual_stepper_pulse_scheduler.sv
// ----------------------------------------------------------------------------
// dual_stepper_pulse_scheduler
// A word's result is registered into out_*, or into the skid word while out_* waits.
// Throughput: one word per cycle while in_stall is low; a two-word output buffer keeps input open
//   while one result waits.
// Each motor lane does its compare, count and due-time add combinationally; the
//   interval multiply runs ahead from the stored speed.
// A config write stalls the input for the next cycle while lane intervals refresh.
// Reset (rst_n low, synchronous) restores register defaults and idle motors.
// ----------------------------------------------------------------------------
module dual_stepper_pulse_scheduler #(
  parameter int NUM_MOTORS = dsps_pkg::DEF_NUM_MOTORS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // command words
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_command,
  input  logic [dsps_pkg::SEL_W-1:0]      in_motor_sel,
  input  logic signed [31:0]              in_step_count,
  input  logic [dsps_pkg::SPEED_W-1:0]    in_speed_q16,
  input  logic [dsps_pkg::TIME_W-1:0]     in_time_us,
  input  logic signed [dsps_pkg::POS_W-1:0] in_enc_pos_a,
  input  logic signed [dsps_pkg::POS_W-1:0] in_enc_pos_b,
  // result words
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_pulse_a,
  output logic                            out_dir_a,
  output logic                            out_pulse_b,
  output logic                            out_dir_b,
  output logic                            out_busy_a,
  output logic                            out_busy_b,
  output logic                            out_status,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dsps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dsps_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; the cycle after a write
  // the input is held off so each lane's registered interval picks up the
  // new bounds before another tick can use it.
  // --------------------------------------------------------------------------
  logic [MIN_W-1:0] min_r;
  logic [MAX_W-1:0] max_r;
  logic             cfg_hold_r;
  logic             cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r      <= RST_MIN;
      max_r      <= RST_MAX;
      cfg_hold_r <= 1'b1;
    end else begin
      cfg_hold_r <= cfg_wr;
      if (cfg_wr && (cfg_index == CFG_MIN_IDX)) begin
        min_r <= cfg_data[MIN_W-1:0];
      end
      if (cfg_wr && (cfg_index == CFG_MAX_IDX)) begin
        max_r <= cfg_data[MAX_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input decode, shared by all lanes
  // --------------------------------------------------------------------------
  logic               in_acc;
  cmd_e               cmd;
  logic               neg;
  logic [31:0]        mag32;
  logic [STEPS_W-1:0] mag;
  logic [SPEED_W-1:0] speed_clamped;
  logic               bad_sel;
  logic               status;

  assign in_acc = in_valid && !in_stall;
  assign cmd    = cmd_e'(in_command);
  assign neg    = in_step_count[31];
  assign mag32  = neg ? (32'd0 - in_step_count) : in_step_count;
  // the most negative count has no positive twin; saturate it
  assign mag    = mag32[31] ? {STEPS_W{1'b1}} : mag32[STEPS_W-1:0];
  assign speed_clamped = (in_speed_q16 > SPEED_ONE) ? SPEED_ONE : in_speed_q16;

  assign bad_sel = (in_motor_sel == '0) || (32'(in_motor_sel) > NUM_MOTORS);
  assign status  = ((cmd == CMD_MOVE) || (cmd == CMD_HOME)) && bad_sel;

  // --------------------------------------------------------------------------
  // Motor lanes. Only the first two lanes see an encoder and take ticks.
  // --------------------------------------------------------------------------
  lane_cmd_t lane_cmd [NUM_MOTORS];
  lane_res_t lane_res [NUM_MOTORS];
  logic [NUM_MOTORS-1:0] lane_pulse;

  for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_lane
    logic             hit;
    logic [POS_W-1:0] pos;

    assign hit = (in_motor_sel == SEL_W'(m + 1));
    assign pos = (m == 0) ? in_enc_pos_a : ((m == 1) ? in_enc_pos_b : '0);

    assign lane_cmd[m].tick  = in_acc && (cmd == CMD_TICK) && (m < 2);
    assign lane_cmd[m].move  = in_acc && (cmd == CMD_MOVE) && hit;
    assign lane_cmd[m].home  = in_acc && (cmd == CMD_HOME) && hit;
    assign lane_cmd[m].halt  = in_acc && (cmd == CMD_HALT);
    assign lane_cmd[m].neg   = neg;
    assign lane_cmd[m].mag   = mag;
    assign lane_cmd[m].speed = speed_clamped;

    dsps_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (lane_cmd[m]),
      .now    (in_time_us),
      .pos    (pos),
      .min_iv (min_r),
      .max_iv (max_r),
      .res    (lane_res[m])
    );

    assign lane_pulse[m] = lane_res[m].pulse;
  end

  // --------------------------------------------------------------------------
  // Merge lane results into one result word
  // --------------------------------------------------------------------------
  res_t res;

  assign res.pulse_a = lane_res[0].pulse;
  assign res.dir_a   = lane_res[0].dir;
  assign res.busy_a  = lane_res[0].busy;
  assign res.status  = status;

  if (NUM_MOTORS > 1) begin : g_lane_b
    assign res.pulse_b = lane_res[1].pulse;
    assign res.dir_b   = lane_res[1].dir;
    assign res.busy_b  = lane_res[1].busy;
  end else begin : g_no_lane_b
    assign res.pulse_b = 1'b0;
    assign res.dir_b   = 1'b0;
    assign res.busy_b  = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Output register plus skid word. in_stall comes from flops only: the skid
  // word being full, or the post-config hold.
  // --------------------------------------------------------------------------
  res_t out_r,  skid_r;
  logic out_v_r, skid_v_r;
  logic out_take;

  assign out_take = out_v_r && !out_stall;
  assign in_stall = skid_v_r || cfg_hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_take) begin
        skid_v_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_v_r && !out_take) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_take) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (in_acc) begin
      if (out_v_r && !out_take) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_valid   = out_v_r;
  assign out_pulse_a = out_r.pulse_a;
  assign out_dir_a   = out_r.dir_a;
  assign out_pulse_b = out_r.pulse_b;
  assign out_dir_b   = out_r.dir_b;
  assign out_busy_a  = out_r.busy_a;
  assign out_busy_b  = out_r.busy_b;
  assign out_status  = out_r.status;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid word held without an output word");

  a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> in_stall)
    else $error("input open right after a register write");

  a_pulse_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (cmd != CMD_TICK)) |-> (lane_pulse == '0))
    else $error("step pulse on a non-tick word");

  a_status_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && status) |-> (lane_pulse == '0))
    else $error("bad motor number together with a step pulse");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: dual stepper pulse scheduler regression
// Directed words, then random command traffic under several interval register
// settings. A scoreboard predicts every result word and checks it field by
// field, with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import dsps_pkg::*;

  localparam int LANES    = 2;     // motors with encoder inputs and outputs
  localparam int WATCHDOG = 3000;  // cycles with no handshake at all
  localparam int HOLD_OFF = 300;   // long receiver stall, fills the block
  localparam int HOLD_AT  = 600;   // result count that triggers it

  // register indexes past the end of the map; writes there are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // one command word as the sender sees it
  typedef struct {
    cmd_e                    cmd;
    logic [SEL_W-1:0]        sel;
    logic signed [31:0]      steps;
    logic [SPEED_W-1:0]      speed;
    logic [TIME_W-1:0]       now;
    logic signed [POS_W-1:0] pos_a;
    logic signed [POS_W-1:0] pos_b;
  } cmd_word_t;

  // ---------------------------------------------------------------- DUT ports
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_command = CMD_TICK;
  logic [SEL_W-1:0]         in_motor_sel = '0;
  logic signed [31:0]       in_step_count = '0;
  logic [SPEED_W-1:0]       in_speed_q16 = '0;
  logic [TIME_W-1:0]        in_time_us = '0;
  logic signed [POS_W-1:0]  in_enc_pos_a = '0;
  logic signed [POS_W-1:0]  in_enc_pos_b = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_pulse_a, out_dir_a, out_pulse_b, out_dir_b;
  logic                     out_busy_a, out_busy_b, out_status;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = CFG_MIN_IDX;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  dual_stepper_pulse_scheduler dut (.*);

  always #5 clk = ~clk;

  // ------------------------------------------------------- scheduler mirror
  // Interval registers and per-motor lane state, as the block should hold them.
  logic [MIN_W-1:0]   reg_min;
  logic [MAX_W-1:0]   reg_max;
  logic [STEPS_W-1:0] lane_steps  [LANES];
  logic [TIME_W-1:0]  lane_due    [LANES];
  logic [SPEED_W-1:0] lane_speed  [LANES];
  logic               lane_fwd    [LANES];
  logic               lane_pin    [LANES];
  logic               lane_homing [LANES];

  // words still to send, and result words predicted but not yet seen
  cmd_word_t cmd_words[$];
  res_t      result_words[$];

  int  items_made, words_in, results_seen, cfg_writes, errors;
  int  pulses_a, pulses_b, bad_sel_seen, settings_run;
  bit  in_taken;            // input word accepted at the last rising edge
  int  quiet;               // watchdog count
  int  send_gap, send_calm, recv_gap, recv_calm, hold_left;
  bit  hold_done;

  // stimulus time base and the register values last written
  logic [31:0] t_now;
  int unsigned stim_min, stim_max;

  initial begin
    reg_min = RST_MIN;
    reg_max = RST_MAX;
    for (int m = 0; m < LANES; m++) begin
      lane_steps[m]  = '0;
      lane_due[m]    = '0;
      lane_speed[m]  = SPEED_ONE;
      lane_fwd[m]    = 1'b1;
      lane_pin[m]    = 1'b0;
      lane_homing[m] = 1'b0;
    end
  end

  // step spacing in us for a Q16 speed: max - speed*(max-min), floored at min
  function automatic logic [31:0] lane_interval(logic [SPEED_W-1:0] spd);
    logic [31:0] lo, hi, iv;
    logic [63:0] prod;
    lo = {16'd0, reg_min};
    hi = {8'd0, reg_max};
    if (hi < lo) return lo;     // registers crossed: min wins
    prod = (64'(spd) * 64'(hi - lo)) >> 16;
    iv = hi - prod[31:0];
    return (iv < lo) ? lo : iv;
  endfunction

  // one motor on a tick; returns the pulse
  function automatic bit lane_tick(int m, logic [31:0] now, logic signed [31:0] pos);
    if (lane_homing[m]) begin
      if (pos == 0) begin       // reached encoder zero: stop, no step
        lane_homing[m] = 1'b0;
        return 1'b0;
      end
      if (now < lane_due[m]) return 1'b0;
      lane_pin[m] = (pos > 0) ? 1'b0 : 1'b1;
    end else begin
      if (lane_steps[m] == 0 || now < lane_due[m]) return 1'b0;
      lane_pin[m] = lane_fwd[m];
      lane_steps[m] = lane_steps[m] - STEPS_W'(1);
    end
    lane_due[m] = now + lane_interval(lane_speed[m]);   // wraps mod 2^32
    return 1'b1;
  endfunction

  // result word for one accepted command word; updates the mirror
  function automatic res_t step_scheduler(cmd_word_t w);
    res_t        r;
    int          m;
    logic [31:0] mag;
    r = '0;
    case (w.cmd)
      CMD_TICK: begin
        r.pulse_a = lane_tick(0, w.now, w.pos_a);
        r.pulse_b = lane_tick(1, w.now, w.pos_b);
      end
      CMD_HALT: begin           // motor select ignored, everything stops
        for (m = 0; m < LANES; m++) begin
          lane_steps[m]  = '0;
          lane_homing[m] = 1'b0;
        end
      end
      default: begin
        if (w.sel == 0 || w.sel > LANES) begin
          r.status = 1'b1;
        end else begin
          m = int'(w.sel) - 1;
          if (w.cmd == CMD_MOVE) begin
            if (w.steps < 0) begin
              mag = 32'd0 - w.steps;
              if (mag > 32'h7FFF_FFFF) mag = 32'h7FFF_FFFF;  // most negative count
              lane_fwd[m] = 1'b0;
            end else begin
              mag = w.steps;
              lane_fwd[m] = 1'b1;
            end
            lane_steps[m] = mag[STEPS_W-1:0];
            lane_speed[m] = (w.speed > SPEED_ONE) ? SPEED_ONE : w.speed;
          end else begin        // home: full speed, homing wins over a move
            lane_homing[m] = 1'b1;
            lane_speed[m]  = SPEED_ONE;
          end
        end
      end
    endcase
    r.dir_a  = lane_pin[0];
    r.dir_b  = lane_pin[1];
    r.busy_a = lane_homing[0] || lane_steps[0] != 0;
    r.busy_b = lane_homing[1] || lane_steps[1] != 0;
    return r;
  endfunction

  // --------------------------------------------------------------- monitor
  // Everything is sampled at the rising edge; inputs moved at the falling one.
  always @(posedge clk) begin : mon
    cmd_word_t   w;
    res_t        want, got;
    bit          busy_edge;
    string       fname [7];
    fname = '{"pulse_a", "dir_a", "pulse_b", "dir_b", "busy_a", "busy_b", "status"};
    in_taken = rst_n && in_valid && !in_stall;
    if (rst_n) begin
      busy_edge = 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_IDX: reg_min = cfg_data[MIN_W-1:0];
          CFG_MAX_IDX: reg_max = cfg_data[MAX_W-1:0];
          default: ;
        endcase
        cfg_writes++;
        busy_edge = 1'b1;
      end
      // predict first: the result of this word can only show up later
      if (in_taken) begin
        w.cmd   = cmd_e'(in_command);
        w.sel   = in_motor_sel;
        w.steps = in_step_count;
        w.speed = in_speed_q16;
        w.now   = in_time_us;
        w.pos_a = in_enc_pos_a;
        w.pos_b = in_enc_pos_b;
        result_words.push_back(step_scheduler(w));
        words_in++;
        busy_edge = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got = '{out_pulse_a, out_dir_a, out_pulse_b, out_dir_b,
                out_busy_a, out_busy_b, out_status};
        if (result_words.size() == 0) begin
          $display("%0t: result word %0d arrived with nothing pending", $time, results_seen);
          errors++;
        end else begin
          want = result_words.pop_front();
          for (int i = 0; i < 7; i++)
            if (got[6-i] !== want[6-i]) begin
              $display("%0t: word %0d %s expected %0b actual %0b",
                       $time, results_seen, fname[i], want[6-i], got[6-i]);
              errors++;
            end
        end
        pulses_a     += int'(out_pulse_a === 1'b1);
        pulses_b     += int'(out_pulse_b === 1'b1);
        bad_sel_seen += int'(out_status === 1'b1);
        results_seen++;
        busy_edge = 1'b1;
      end
      quiet = busy_edge ? 0 : quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("%0t: no handshake for %0d cycles, %0d words in, %0d out",
                 $time, WATCHDOG, words_in, results_seen);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- pacing
  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sender: a word is held until taken, then the next one after a random gap
  always @(negedge clk) begin : drive
    cmd_word_t nxt;
    if (rst_n && (!in_valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (cmd_words.size() != 0) begin
        nxt = cmd_words.pop_front();
        in_command    <= nxt.cmd;
        in_motor_sel  <= nxt.sel;
        in_step_count <= nxt.steps;
        in_speed_q16  <= nxt.speed;
        in_time_us    <= nxt.now;
        in_enc_pos_a  <= nxt.pos_a;
        in_enc_pos_b  <= nxt.pos_b;
        in_valid      <= 1'b1;
        if (send_calm > 0) send_calm--;
        else if ($urandom_range(0, 99) == 0) send_calm = $urandom_range(40, 150);
        send_gap = pick_gap(send_calm > 0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off so the input backs up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_OFF - 1;
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (recv_calm > 0) recv_calm--;
      else if ($urandom_range(0, 99) == 0) recv_calm = $urandom_range(40, 150);
      recv_gap = pick_gap(recv_calm > 0);
    end
  end

  // ------------------------------------------------------------- stimulus
  task automatic push_word(cmd_e c, logic [SEL_W-1:0] s, logic signed [31:0] n,
                           logic [SPEED_W-1:0] v, logic [31:0] t,
                           logic signed [31:0] pa, logic signed [31:0] pb);
    cmd_word_t w;
    w = '{c, s, n, v, t, pa, pb};
    cmd_words.push_back(w);
    items_made++;
  endtask

  // encoder reading: zero often enough that homing ends
  function automatic logic [31:0] enc_pick();
    case ($urandom_range(0, 9))
      0, 1, 2: return 32'd0;
      3, 4, 5: return 32'($urandom_range(0, 10)) - 32'd5;
      6:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // mostly short moves so motors finish and restart under traffic
  function automatic logic [31:0] steps_pick();
    logic [31:0] mag;
    mag = $urandom_range(1, 12);
    case ($urandom_range(0, 9))
      6:       return 32'd0;
      7:       return 32'h8000_0000;
      8:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0001;
      9:       return $urandom;
      default: return $urandom_range(0, 1) ? mag : 32'd0 - mag;
    endcase
  endfunction

  function automatic logic [SPEED_W-1:0] speed_pick();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return SPEED_ONE;
      2:       return SPEED_W'($urandom_range(32'h10001, 32'h1FFFF));  // clamps to 1.0
      default: return SPEED_W'($urandom_range(0, 32'h10000));
    endcase
  endfunction

  function automatic logic [SEL_W-1:0] sel_pick();
    if ($urandom_range(0, 99) < 85) return SEL_W'($urandom_range(1, LANES));
    return SEL_W'($urandom_range(0, 15));
  endfunction

  // tick time: mostly forward by up to a fraction of the interval span,
  // sometimes stuck, stepping back, or jumping anywhere (wrap included)
  function automatic logic [31:0] time_pick();
    int unsigned span;
    span = ((stim_max > stim_min) ? stim_max : stim_min) / 3 + 2;
    case ($urandom_range(0, 19))
      0:       t_now = $urandom;
      1:       t_now = t_now - $urandom_range(0, 50);
      2:       ;
      default: t_now = t_now + $urandom_range(0, span);
    endcase
    return t_now;
  endfunction

  task automatic gen_traffic(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 68)
        push_word(CMD_TICK, SEL_W'($urandom), $urandom, SPEED_W'($urandom), time_pick(),
                  enc_pick(), enc_pick());
      else if (r < 83)
        push_word(CMD_MOVE, sel_pick(), steps_pick(), speed_pick(), $urandom, $urandom,
                  $urandom);
      else if (r < 91)
        push_word(CMD_HOME, sel_pick(), $urandom, SPEED_W'($urandom), $urandom, $urandom,
                  $urandom);
      else if (r < 94)
        push_word(CMD_HALT, SEL_W'($urandom), $urandom, SPEED_W'($urandom), $urandom,
                  $urandom, $urandom);
      else  // noise: any command, every field random
        push_word(cmd_e'($urandom_range(0, 3)), SEL_W'($urandom), $urandom,
                  SPEED_W'($urandom), $urandom, $urandom, $urandom);
    end
  endtask

  // wait for every predicted word, then let the block settle
  task automatic drain();
    while (results_seen != items_made) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    int seen;
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    seen = cfg_writes;
    do @(negedge clk); while (cfg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  initial begin : run
    int unsigned lo, hi;
    t_now    = '0;
    stim_min = 32'(RST_MIN);
    stim_max = 32'(RST_MAX);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part at reset register values (min 10, max 100000)
    push_word(CMD_TICK, 0, 0, 0, 0, 0, 0);                      // idle tick
    push_word(CMD_MOVE, 1, 3, SPEED_ONE, 0, 0, 0);              // full speed fwd
    push_word(CMD_MOVE, 2, -2, 0, 0, 0, 0);                     // zero speed back
    push_word(CMD_TICK, 0, 0, 0, 0, 5, -5);
    push_word(CMD_TICK, 0, 0, 0, 9, 5, -5);                     // not yet due
    push_word(CMD_TICK, 0, 0, 0, 10, 5, -5);
    push_word(CMD_MOVE, 1, 32'h8000_0000, 17'h1FFFF, 0, 0, 0);  // saturate, clamp
    push_word(CMD_MOVE, 0, 5, 100, 0, 0, 0);                    // no motor zero
    push_word(CMD_HOME, 15, 0, 0, 0, 0, 0);                     // motor out of range
    push_word(CMD_HOME, 2, 0, 0, 0, 0, 0);
    push_word(CMD_TICK, 0, 0, 0, 100000, 1, 7);                 // home from above
    push_word(CMD_TICK, 0, 0, 0, 200000, 1, -3);                // home from below
    push_word(CMD_MOVE, 2, 5, 100, 0, 0, 0);                    // move while homing
    push_word(CMD_TICK, 0, 0, 0, 300000, 1, -3);
    push_word(CMD_TICK, 0, 0, 0, 300001, 1, 0);                 // homing ends here
    push_word(CMD_TICK, 0, 0, 0, 400000, 1, 0);                 // move takes over
    push_word(CMD_HALT, 9, 0, 0, 0, 0, 0);                      // select ignored
    push_word(CMD_TICK, 0, 0, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    push_word(CMD_MOVE, 1, 32'h7FFF_FFFF, SPEED_ONE, 0, 0, 0);
    push_word(CMD_TICK, 0, 0, 0, 32'hFFFF_FFFA, 0, 0);          // due wraps to 4
    push_word(CMD_TICK, 0, 0, 0, 0, 0, 0);                      // wrapped, not due
    push_word(CMD_TICK, 0, 0, 0, 5, 0, 0);
    push_word(CMD_HALT, 0, 0, 0, 0, 0, 0);
    drain();

    // random phases, each under its own interval registers
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       begin lo = 1;     hi = 1;          end
        1:       begin lo = 65535; hi = 24'hFF_FFFF; end
        2:       begin lo = 65535; hi = 1;          end   // max below min
        3:       begin lo = 1;     hi = 24'hFF_FFFF; end
        default: begin lo = $urandom_range(1, 40); hi = $urandom_range(1, 3000); end
      endcase
      // junk in the upper byte of the min write must be dropped
      set_reg(CFG_MIN_IDX, {8'($urandom), 16'(lo)});
      set_reg(CFG_MAX_IDX, 24'(hi));
      if (p == 4) begin
        set_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
        set_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
      end
      stim_min = lo;
      stim_max = hi;
      settings_run++;
      gen_traffic(p < 4 ? 180 : 300);
      drain();
    end

    $display("covered %0d command words over %0d register settings, %0d register writes",
             words_in, settings_run + 1, cfg_writes);
    $display("saw %0d / %0d step pulses on motors 1 / 2 and %0d bad motor selects",
             pulses_a, pulses_b, bad_sel_seen);
    if (errors == 0 && result_words.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: dual_stepper_pulse_scheduler.f
hdl/dsps_pkg.sv
hdl/dsps_interval.sv
hdl/dsps_lane.sv
hdl/dual_stepper_pulse_scheduler.sv
tb/sv/tb.sv
